// ===== hw/rtl/ksrlp_pkg.sv =====
// Shared types and constants for the three-button key scanner.
// Used by the channel interfaces and the top level; depends on nothing.
package ksrlp_pkg;

    typedef struct packed {
        logic mode;
        logic btn_one_down;
        logic btn_two_down;
        logic btn_three_down;
    } item_t;

    typedef struct packed {
        logic [2:0] key_code;
        logic       hold_pulse;
    } result_t;

    localparam int PERIOD_W = 8;
    localparam int HOLD_W   = 11;
    localparam int CODE_W   = 3;
    localparam int CFG_W    = 11;
    localparam int INDEX_W  = 1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [INDEX_W-1:0] REG_SAMPLE_PERIOD  = 1'd0;
    localparam logic [INDEX_W-1:0] REG_HOLD_THRESHOLD = 1'd1;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 8'd20;
    localparam logic [HOLD_W-1:0]   HOLD_THRESHOLD_RST = 11'd1000;
    localparam logic [HOLD_W-1:0]   HOLD_COUNT_MAX     = 11'd2047;

    localparam logic [CODE_W-1:0] KEY_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] KEY_ONE   = 3'd1;
    localparam logic [CODE_W-1:0] KEY_TWO   = 3'd2;
    localparam logic [CODE_W-1:0] KEY_THREE = 3'd3;
    localparam logic [CODE_W-1:0] KEY_LONG  = 3'd4;

endpackage

// ===== hw/rtl/ksrlp_if.sv =====
// Valid/ready channel interfaces for the key scanner requests and results.
// Depends on ksrlp_pkg for the payload types.
interface ksrlp_item_if;
    logic              valid;
    logic              ready;
    ksrlp_pkg::item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ksrlp_result_if;
    logic               valid;
    logic               ready;
    ksrlp_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/key_scan_release_long_press.sv =====
// Three-button key scanner: long press on button three, periodic sampling,
// release latch and read-and-clear. Depends on ksrlp_pkg and ksrlp_if.
//
// Every request (tick or read) gives exactly one result. A request is taken in
// every cycle: all counter, sample and release work is one short pass of logic
// into the state registers, and the result lands in a single output register
// in the cycle after acceptance. The input stalls only while that output register
// holds a result that the sink has not taken in the same cycle.
module key_scan_release_long_press (
    input  logic                              clk,
    input  logic                              rst_n,
    ksrlp_item_if.sink                        item,
    ksrlp_result_if.source                    result,
    input  logic                              cfg_we,
    input  logic [ksrlp_pkg::INDEX_W-1:0]     cfg_index,
    input  logic [ksrlp_pkg::CFG_W-1:0]       cfg_data
);

    logic [ksrlp_pkg::PERIOD_W-1:0] sample_period_reg;
    logic [ksrlp_pkg::HOLD_W-1:0]   hold_threshold_reg;
    logic [ksrlp_pkg::PERIOD_W-1:0] tick_div_reg;
    logic [ksrlp_pkg::HOLD_W-1:0]   hold_counter_reg;
    logic [ksrlp_pkg::CODE_W-1:0]   prev_sample_reg;
    logic [ksrlp_pkg::CODE_W-1:0]   cur_sample_reg;
    logic [ksrlp_pkg::CODE_W-1:0]   pending_code_reg;
    logic                           out_valid_reg;
    ksrlp_pkg::result_t             out_data_reg;

    logic [ksrlp_pkg::PERIOD_W-1:0] tick_div_next;
    logic [ksrlp_pkg::HOLD_W-1:0]   hold_counter_next;
    logic [ksrlp_pkg::CODE_W-1:0]   prev_sample_next;
    logic [ksrlp_pkg::CODE_W-1:0]   cur_sample_next;
    logic [ksrlp_pkg::CODE_W-1:0]   pending_code_next;
    ksrlp_pkg::result_t             out_data_next;

    logic [ksrlp_pkg::PERIOD_W-1:0] tick_inc;
    logic                           take;
    logic                           accept;
    logic                           wrap;
    logic [ksrlp_pkg::CODE_W-1:0]   sample;

    assign item.ready    = !out_valid_reg || result.ready;
    assign accept        = item.valid && item.ready;
    assign result.valid  = out_valid_reg;
    assign result.payload = out_data_reg;

    always_comb
    begin
        tick_div_next     = tick_div_reg;
        hold_counter_next = hold_counter_reg;
        prev_sample_next  = prev_sample_reg;
        cur_sample_next   = cur_sample_reg;
        pending_code_next = pending_code_reg;
        out_data_next     = '0;
        wrap              = 1'b0;
        sample            = ksrlp_pkg::KEY_NONE;
        tick_inc          = tick_div_reg + 8'd1;
        take              = (tick_inc >= sample_period_reg);

        if (item.payload.mode == ksrlp_pkg::MODE_READ)
        begin
            out_data_next.key_code = pending_code_reg;
            pending_code_next      = ksrlp_pkg::KEY_NONE;
        end
        else
        begin
            // count up to threshold+1, then wrap with a pulse; also wrap at the counter's top
            if (item.payload.btn_three_down)
            begin
                if (hold_counter_reg <= hold_threshold_reg &&
                    hold_counter_reg != ksrlp_pkg::HOLD_COUNT_MAX)
                begin
                    hold_counter_next = hold_counter_reg + 11'd1;
                end
                else
                begin
                    hold_counter_next = '0;
                    wrap              = 1'b1;
                end
            end
            else
            begin
                hold_counter_next = '0;
            end
            out_data_next.hold_pulse = wrap;

            // priority sample uses the already updated hold counter
            if (item.payload.btn_one_down)
                sample = ksrlp_pkg::KEY_ONE;
            else if (item.payload.btn_two_down)
                sample = ksrlp_pkg::KEY_TWO;
            else if (item.payload.btn_three_down)
                sample = (hold_counter_next >= hold_threshold_reg) ?
                         ksrlp_pkg::KEY_LONG : ksrlp_pkg::KEY_THREE;

            if (take)
            begin
                tick_div_next    = '0;
                prev_sample_next = cur_sample_reg;
                cur_sample_next  = sample;
                if (cur_sample_reg != ksrlp_pkg::KEY_NONE &&
                    sample == ksrlp_pkg::KEY_NONE)
                    pending_code_next = cur_sample_reg;
            end
            else
            begin
                tick_div_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg  <= ksrlp_pkg::SAMPLE_PERIOD_RST;
            hold_threshold_reg <= ksrlp_pkg::HOLD_THRESHOLD_RST;
            tick_div_reg       <= '0;
            hold_counter_reg   <= '0;
            prev_sample_reg    <= ksrlp_pkg::KEY_NONE;
            cur_sample_reg     <= ksrlp_pkg::KEY_NONE;
            pending_code_reg   <= ksrlp_pkg::KEY_NONE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ksrlp_pkg::REG_SAMPLE_PERIOD:
                        sample_period_reg <= cfg_data[ksrlp_pkg::PERIOD_W-1:0];
                    ksrlp_pkg::REG_HOLD_THRESHOLD:
                        hold_threshold_reg <= cfg_data[ksrlp_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                tick_div_reg     <= tick_div_next;
                hold_counter_reg <= hold_counter_next;
                prev_sample_reg  <= prev_sample_next;
                cur_sample_reg   <= cur_sample_next;
                pending_code_reg <= pending_code_next;
                out_valid_reg    <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload holds while the result waits
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.payload.mode == ksrlp_pkg::MODE_READ
        |=> pending_code_reg == ksrlp_pkg::KEY_NONE)
        else $error("pending code not cleared after read");

    a_release_zeroes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.payload.mode == ksrlp_pkg::MODE_TICK &&
        !item.payload.btn_three_down
        |=> hold_counter_reg == '0)
        else $error("hold counter not zeroed on release");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.key_code != ksrlp_pkg::KEY_NONE
        |-> !out_data_reg.hold_pulse)
        else $error("read result carries a hold pulse");

    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule

// ===== test/key_scan_release_long_press_test.sv =====
`timescale 1ns / 1ps
// Testbench for the three-button key scanner: directed ticks and reads, then press
// gestures under several sample periods and hold thresholds, checked against a predictor.
// Depends on ksrlp_pkg, the ksrlp_if channel interfaces and key_scan_release_long_press.
module key_scan_release_long_press_test;

    class key_scan_scoreboard;
        logic [ksrlp_pkg::PERIOD_W-1:0] sample_period;
        logic [ksrlp_pkg::HOLD_W-1:0]   hold_threshold;
        logic [ksrlp_pkg::PERIOD_W-1:0] tick_div;
        logic [ksrlp_pkg::HOLD_W-1:0]   hold_count;
        logic [ksrlp_pkg::CODE_W-1:0]   prev_code;
        logic [ksrlp_pkg::CODE_W-1:0]   cur_code;
        logic [ksrlp_pkg::CODE_W-1:0]   pending_code;
        ksrlp_pkg::result_t             awaited_results[$];
        int                             fail_count;

        function new();
            sample_period  = ksrlp_pkg::SAMPLE_PERIOD_RST;
            hold_threshold = ksrlp_pkg::HOLD_THRESHOLD_RST;
            tick_div       = '0;
            hold_count     = '0;
            prev_code      = ksrlp_pkg::KEY_NONE;
            cur_code       = ksrlp_pkg::KEY_NONE;
            pending_code   = ksrlp_pkg::KEY_NONE;
            fail_count     = 0;
        endfunction

        function void set_register(logic [ksrlp_pkg::INDEX_W-1:0] index,
                                   logic [ksrlp_pkg::CFG_W-1:0] data);
            if (index == ksrlp_pkg::REG_SAMPLE_PERIOD)
                sample_period = data[ksrlp_pkg::PERIOD_W-1:0];
            else if (index == ksrlp_pkg::REG_HOLD_THRESHOLD)
                hold_threshold = data[ksrlp_pkg::HOLD_W-1:0];
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void note_request(ksrlp_pkg::item_t req);
            ksrlp_pkg::result_t want;
            want = '0;
            if (req.mode == ksrlp_pkg::MODE_READ)
            begin
                want.key_code = pending_code;
                pending_code  = ksrlp_pkg::KEY_NONE;
            end
            else
            begin
                // count up to threshold+1, wrap on the next held tick or at the counter's top
                if (req.btn_three_down)
                begin
                    if (int'(hold_count) < int'(hold_threshold) + 1 &&
                        hold_count < ksrlp_pkg::HOLD_COUNT_MAX)
                        hold_count = hold_count + 1'b1;
                    else
                    begin
                        hold_count      = '0;
                        want.hold_pulse = 1'b1;
                    end
                end
                else
                    hold_count = '0;

                tick_div = tick_div + 1'b1;
                if (tick_div >= sample_period)
                begin
                    tick_div  = '0;
                    prev_code = cur_code;
                    if (req.btn_one_down)
                        cur_code = ksrlp_pkg::KEY_ONE;
                    else if (req.btn_two_down)
                        cur_code = ksrlp_pkg::KEY_TWO;
                    else if (req.btn_three_down)
                        cur_code = (hold_count >= hold_threshold) ?
                                   ksrlp_pkg::KEY_LONG : ksrlp_pkg::KEY_THREE;
                    else
                        cur_code = ksrlp_pkg::KEY_NONE;
                    if (prev_code != ksrlp_pkg::KEY_NONE && cur_code == ksrlp_pkg::KEY_NONE)
                        pending_code = prev_code;
                end
            end
            awaited_results.push_back(want);
        endfunction

        task report(string what);
            fail_count++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(ksrlp_pkg::result_t got);
            ksrlp_pkg::result_t want;
            if (awaited_results.size() == 0)
                report($sformatf("unexpected result key_code=%0d hold_pulse=%0d",
                                 got.key_code, got.hold_pulse));
            else
            begin
                want = awaited_results.pop_front();
                if (got.key_code !== want.key_code)
                    report($sformatf("key_code got %0d want %0d", got.key_code, want.key_code));
                if (got.hold_pulse !== want.hold_pulse)
                    report($sformatf("hold_pulse got %0d want %0d",
                                     got.hold_pulse, want.hold_pulse));
            end
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ksrlp_pkg::INDEX_W-1:0]  cfg_index;
    logic [ksrlp_pkg::CFG_W-1:0]    cfg_data;
    bit                             quiet;
    bit                             holdoff_req;
    int                             sent_reqs;
    key_scan_scoreboard             sb;

    ksrlp_item_if   key_req();
    ksrlp_result_if key_res();

    key_scan_release_long_press dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (key_req),
        .result    (key_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (key_res.valid && key_res.ready)
            sb.check_result(key_res.payload);
        if (key_req.valid && key_req.ready)
            sb.note_request(key_req.payload);
    end

    // result sink: random stalls, or a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        key_res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                stall_left  = 150;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                key_res.ready <= 1'b0;
            end
            else
                key_res.ready <= quiet || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic offer_request(ksrlp_pkg::item_t req);
        while (!quiet && $urandom_range(99) < 30)
        begin
            key_req.valid <= 1'b0;
            @(posedge clk);
        end
        key_req.valid   <= 1'b1;
        key_req.payload <= req;
        do
            @(posedge clk);
        while (!key_req.ready);
        sent_reqs++;
    endtask

    task automatic drain_results();
        key_req.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic configure(int period, int thr);
        cfg_we    <= 1'b1;
        cfg_index <= ksrlp_pkg::REG_SAMPLE_PERIOD;
        cfg_data  <= ksrlp_pkg::CFG_W'(period);
        @(posedge clk);
        sb.set_register(ksrlp_pkg::REG_SAMPLE_PERIOD, ksrlp_pkg::CFG_W'(period));
        cfg_index <= ksrlp_pkg::REG_HOLD_THRESHOLD;
        cfg_data  <= ksrlp_pkg::CFG_W'(thr);
        @(posedge clk);
        sb.set_register(ksrlp_pkg::REG_HOLD_THRESHOLD, ksrlp_pkg::CFG_W'(thr));
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int period, int thr, int budget, bit pressure);
        int               stop_at;
        int               hold_len;
        int               gap_len;
        int               k;
        bit [2:0]         mask;
        bit               first;
        bit               did_holdoff;
        bit               did_pause;
        ksrlp_pkg::item_t req;
        stop_at     = sent_reqs + budget;
        first       = 1'b1;
        did_holdoff = 1'b0;
        did_pause   = 1'b0;
        while (sent_reqs < stop_at)
        begin
            if (pressure && !did_holdoff && sent_reqs >= stop_at - 2 * budget / 3)
            begin
                holdoff_req = 1'b1;
                did_holdoff = 1'b1;
            end
            if (pressure && !did_pause && sent_reqs >= stop_at - budget / 3)
            begin
                drain_results();
                did_pause = 1'b1;
            end

            if (!first && $urandom_range(99) < 15)
            begin
                // noise: random levels, some reads
                hold_len = $urandom_range(1, 2 * period + 4);
                for (k = 0; k < hold_len; k++)
                begin
                    req = ksrlp_pkg::item_t'(4'($urandom_range(15)));
                    if ($urandom_range(99) >= 20)
                        req.mode = ksrlp_pkg::MODE_TICK;
                    offer_request(req);
                end
            end
            else
            begin
                // mask bits: 0 = button one, 1 = button two, 2 = button three
                case ($urandom_range(9))
                    0, 1, 2: mask = 3'b001;
                    3, 4:    mask = 3'b010;
                    5, 6, 7: mask = 3'b100;
                    8:       mask = 3'($urandom_range(1, 7));
                    default: mask = 3'b111;
                endcase
                if (first)
                    mask = 3'b100;
                if (mask[2] && (first || $urandom_range(99) < 30))
                begin
                    hold_len = thr + 2 + $urandom_range(0, 2 * period + 4);
                    if (thr < 100)
                        hold_len = hold_len * $urandom_range(1, 3);
                end
                else
                    hold_len = $urandom_range(1, 3 * period + 2);
                gap_len = $urandom_range(1, 3 * period + 2);

                for (k = 0; k < hold_len + gap_len; k++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        req      = ksrlp_pkg::item_t'(4'($urandom_range(15)));
                        req.mode = ksrlp_pkg::MODE_READ;
                        offer_request(req);
                    end
                    req.mode           = ksrlp_pkg::MODE_TICK;
                    req.btn_one_down   = mask[0] && k < hold_len;
                    req.btn_two_down   = mask[1] && k < hold_len;
                    req.btn_three_down = mask[2] && k < hold_len;
                    offer_request(req);
                end
                if ($urandom_range(99) < 60)
                begin
                    req      = ksrlp_pkg::item_t'(4'($urandom_range(15)));
                    req.mode = ksrlp_pkg::MODE_READ;
                    offer_request(req);
                end
            end
            first = 1'b0;
        end
    endtask

    initial
    begin
        ksrlp_pkg::item_t directed_reqs[23] = '{
            '{ksrlp_pkg::MODE_READ, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b1, 1'b1, 1'b1},
            '{ksrlp_pkg::MODE_READ, 1'b1, 1'b1, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_READ, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_READ, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b1, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_READ, 1'b1, 1'b1, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_TICK, 1'b1, 1'b1, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b1, 1'b1},
            '{ksrlp_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0},
            '{ksrlp_pkg::MODE_READ, 1'b0, 1'b0, 1'b0}
        };
        int phase_period[6]   = '{1, 3, 13, 20, 2, 7};
        int phase_thr[6]      = '{1, 17, 5, 700, 30, 40};
        int phase_budget[6]   = '{120, 100, 60, 1, 60, 60};
        bit phase_pressure[6] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        bit phase_quiet[6]    = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

        sb              = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        key_req.valid   = 1'b0;
        key_req.payload = '0;
        quiet           = 1'b0;
        holdoff_req     = 1'b0;
        sent_reqs       = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first requests run under the reset settings, the rest sample on every tick
        for (int i = 0; i < 23; i++)
        begin
            offer_request(directed_reqs[i]);
            if (i == 2)
            begin
                drain_results();
                configure(1, 2);
            end
        end
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            configure(phase_period[p], phase_thr[p]);
            quiet = phase_quiet[p];
            run_phase(phase_period[p], phase_thr[p], phase_budget[p], phase_pressure[p]);
            drain_results();
            quiet = 1'b0;
        end

        repeat (4) @(posedge clk);
        if (sb.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
